### sv/pwmtb_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time functions for the PWM time-base block.
// No dependencies.
package pwmtb_pkg;

    localparam longint unsigned NS_SCALED = 64'd256000000000;
    localparam longint unsigned DIV_UNIT  = 64'd655350;
    localparam longint unsigned MAX_DIV   = 64'd1792;
    localparam longint unsigned TICK_NS   = 64'd10;
    localparam int              FULL_DUTY = 25600;

    // Frequencies at or below this value are too slow for any prescaler.
    localparam longint unsigned SLOW_MAX = (NS_SCALED - 64'd1) / (MAX_DIV * DIV_UNIT);

    localparam int N_ENT      = 64;
    localparam int DIV_STAGES = 8;
    localparam int DIV_STEP   = 2;
    localparam int Q_W        = DIV_STAGES * DIV_STEP;
    localparam int C_W        = 35;
    localparam int REM_W      = 36;

    // floor(x/100) for x below 2^23 as (x * RECIP) >> RECIP_SH
    localparam int              RECIP_SH = 30;
    localparam longint unsigned RECIP    = ((64'd1 << RECIP_SH) + 64'd99) / 64'd100;

    localparam logic [1:0] ADDR_MIN_FREQ = 2'd0;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_TOO_SLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  inst;
        logic        slow;
        logic        inval;
        logic [14:0] da;
        logic [14:0] db;
    } t_side;

    function automatic longint unsigned hs_of(input logic [2:0] j);
        longint unsigned v;
        unique case (j)
            3'd0: v = 64'd1;
            3'd1: v = 64'd2;
            3'd2: v = 64'd4;
            3'd3: v = 64'd6;
            3'd4: v = 64'd8;
            3'd5: v = 64'd10;
            3'd6: v = 64'd12;
            3'd7: v = 64'd14;
            default: v = 64'd1;
        endcase
        return v;
    endfunction

    function automatic longint unsigned prod_of(input logic [5:0] e);
        return hs_of(e[2:0]) << e[5:3];
    endfunction

    // Position of an entry when sorted by product, ties by entry number.
    function automatic int rank_of(input logic [5:0] e);
        int r;
        longint unsigned k;
        longint unsigned k2;
        r = 0;
        k = prod_of(e) * 64 + 64'(e);
        for (int m = 0; m < N_ENT; m++) begin
            k2 = prod_of(6'(m)) * 64 + 64'(m);
            if (k2 < k) begin
                r = r + 1;
            end
        end
        return r;
    endfunction

endpackage

### sv/pwmtb_select.sv
`timescale 1ns / 1ps
// Prescaler selection: threshold compares, then priority pick and dividend lookup.
// Depends on pwmtb_pkg.
module pwmtb_select import pwmtb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_instance_req,
    input  logic [31:0]        i_frequency,
    input  logic signed [15:0] i_duty_a,
    input  logic signed [15:0] i_duty_b,
    input  logic [31:0]        i_min_freq,
    output logic               o_valid,
    output logic [31:0]        o_freq,
    output logic [C_W-1:0]     o_dividend,
    output logic [2:0]         o_ci,
    output logic [2:0]         o_hi,
    output t_side              o_side
);

    logic [N_ENT-1:0] w_q_sorted;
    logic [5:0]       w_ent_by_rank [N_ENT];
    logic [C_W-1:0]   w_c_tab       [N_ENT];

    for (genvar e = 0; e < N_ENT; e++) begin : g_ent
        localparam longint unsigned P = prod_of(6'(e));
        localparam longint unsigned T = NS_SCALED / (DIV_UNIT * P);
        localparam longint unsigned C = NS_SCALED / (TICK_NS * P);
        localparam int R = rank_of(6'(e));
        assign w_q_sorted[R]    = (64'(i_frequency) > T);
        assign w_ent_by_rank[R] = 6'(e);
        assign w_c_tab[e]       = C_W'(C);
    end

    function automatic logic [14:0] clamp_duty(input logic signed [15:0] d);
        logic [14:0] r;
        if (d < 0) begin
            r = '0;
        end else if (d > 16'(FULL_DUTY)) begin
            r = 15'(FULL_DUTY);
        end else begin
            r = d[14:0];
        end
        return r;
    endfunction

    // Stage 1: compares and flags
    logic             r_v1, n_v1;
    logic [N_ENT-1:0] r_q;
    logic [31:0]      r_f;
    t_side            r_side1, n_side1;

    always_comb begin
        n_v1          = i_valid;
        n_side1.inst  = i_instance_req;
        n_side1.slow  = (64'(i_frequency) <= SLOW_MAX);
        n_side1.inval = (i_frequency <= i_min_freq) ||
                        (i_duty_a < 0) || (i_duty_a > 16'(FULL_DUTY)) ||
                        (i_duty_b < 0) || (i_duty_b > 16'(FULL_DUTY));
        n_side1.da    = clamp_duty(i_duty_a);
        n_side1.db    = clamp_duty(i_duty_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
        end
        r_q     <= w_q_sorted;
        r_f     <= i_frequency;
        r_side1 <= n_side1;
    end

    // Stage 2: first qualifying product in sorted order, default the largest entry
    logic [5:0] w_rank;
    logic       w_found;
    logic [5:0] w_ent;

    always_comb begin
        w_rank  = '0;
        w_found = 1'b0;
        for (int n = N_ENT - 1; n >= 0; n--) begin
            if (r_q[n]) begin
                w_rank  = 6'(n);
                w_found = 1'b1;
            end
        end
        w_ent = w_found ? w_ent_by_rank[w_rank] : 6'(N_ENT - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v1;
        end
        o_freq     <= r_f;
        o_dividend <= w_c_tab[w_ent];
        o_ci       <= w_ent[5:3];
        o_hi       <= w_ent[2:0];
        o_side     <= r_side1;
    end

endmodule

### sv/pwmtb_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: period = dividend / frequency, two quotient bits a stage.
// Depends on pwmtb_pkg.
module pwmtb_div import pwmtb_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [31:0]    i_freq,
    input  logic [C_W-1:0] i_dividend,
    input  logic [2:0]     i_ci,
    input  logic [2:0]     i_hi,
    input  t_side          i_side,
    output logic           o_valid,
    output logic [Q_W-1:0] o_quot,
    output logic [2:0]     o_ci,
    output logic [2:0]     o_hi,
    output t_side          o_side
);

    logic             r_v   [DIV_STAGES+1];
    logic [REM_W-1:0] r_rem [DIV_STAGES+1];
    logic [Q_W-1:0]   r_q   [DIV_STAGES+1];
    logic [31:0]      r_f   [DIV_STAGES+1];
    logic [2:0]       r_ci  [DIV_STAGES+1];
    logic [2:0]       r_hi  [DIV_STAGES+1];
    t_side            r_sd  [DIV_STAGES+1];

    always_comb begin
        r_v[0]   = i_valid;
        r_rem[0] = REM_W'(i_dividend);
        r_q[0]   = '0;
        r_f[0]   = i_freq;
        r_ci[0]  = i_ci;
        r_hi[0]  = i_hi;
        r_sd[0]  = i_side;
    end

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [REM_W-1:0] n_rem;
        logic [Q_W-1:0]   n_q;
        logic [47:0]      w_sh;

        always_comb begin
            n_rem = r_rem[s];
            n_q   = r_q[s];
            w_sh  = '0;
            for (int b = 0; b < DIV_STEP; b++) begin
                w_sh = 48'(r_f[s]) << (Q_W - 1 - s * DIV_STEP - b);
                if (48'(n_rem) >= w_sh) begin
                    n_rem = n_rem - REM_W'(w_sh);
                    n_q[Q_W - 1 - s * DIV_STEP - b] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
            r_rem[s+1] <= n_rem;
            r_q[s+1]   <= n_q;
            r_f[s+1]   <= r_f[s];
            r_ci[s+1]  <= r_ci[s];
            r_hi[s+1]  <= r_hi[s];
            r_sd[s+1]  <= r_sd[s];
        end
    end

    assign o_valid = r_v[DIV_STAGES];
    assign o_quot  = r_q[DIV_STAGES];
    assign o_ci    = r_ci[DIV_STAGES];
    assign o_hi    = r_hi[DIV_STAGES];
    assign o_side  = r_sd[DIV_STAGES];

endmodule

### sv/pwmtb_cmp.sv
`timescale 1ns / 1ps
// Compare values floor(period*duty/25600) and final result register.
// Depends on pwmtb_pkg.
module pwmtb_cmp import pwmtb_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [Q_W-1:0] i_period,
    input  logic [2:0]     i_ci,
    input  logic [2:0]     i_hi,
    input  t_side          i_side,
    output logic           o_valid,
    output logic [1:0]     o_target_instance,
    output logic [2:0]     o_clock_div_index,
    output logic [2:0]     o_highspeed_div_index,
    output logic [15:0]    o_period,
    output logic [15:0]    o_compare_a,
    output logic [15:0]    o_compare_b,
    output logic [1:0]     o_status
);

    // Stage A: period times clamped duty
    logic        r_va;
    logic [30:0] r_pa, r_pb;
    logic [15:0] r_per_a;
    logic [2:0]  r_ci_a, r_hi_a;
    t_side       r_sd_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= i_valid;
        end
        r_pa    <= 31'(i_period) * 31'(i_side.da);
        r_pb    <= 31'(i_period) * 31'(i_side.db);
        r_per_a <= i_period;
        r_ci_a  <= i_ci;
        r_hi_a  <= i_hi;
        r_sd_a  <= i_side;
    end

    // Stage B: divide by 256 with a shift, by 100 with a reciprocal
    logic        r_vb;
    logic [46:0] r_ra, r_rb;
    logic [15:0] r_per_b;
    logic [2:0]  r_ci_b, r_hi_b;
    t_side       r_sd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= r_va;
        end
        r_ra    <= 47'(r_pa[30:8]) * 47'(RECIP);
        r_rb    <= 47'(r_pb[30:8]) * 47'(RECIP);
        r_per_b <= r_per_a;
        r_ci_b  <= r_ci_a;
        r_hi_b  <= r_hi_a;
        r_sd_b  <= r_sd_a;
    end

    // Output: zero everything but the instance and the status when too slow
    t_status w_st;

    always_comb begin
        priority if (r_sd_b.slow) begin
            w_st = ST_TOO_SLOW;
        end else if (r_sd_b.inval) begin
            w_st = ST_INVALID;
        end else begin
            w_st = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vb;
        end
        o_target_instance     <= r_sd_b.inst;
        o_status              <= w_st;
        o_clock_div_index     <= r_sd_b.slow ? 3'd0  : r_ci_b;
        o_highspeed_div_index <= r_sd_b.slow ? 3'd0  : r_hi_b;
        o_period              <= r_sd_b.slow ? 16'd0 : r_per_b;
        o_compare_a           <= r_sd_b.slow ? 16'd0 : r_ra[RECIP_SH+15:RECIP_SH];
        o_compare_b           <= r_sd_b.slow ? 16'd0 : r_rb[RECIP_SH+15:RECIP_SH];
    end

endmodule

### sv/pwm_frequency_to_timebase.sv
`timescale 1ns / 1ps
// Top level of the PWM time-base calculator: register port, selection, divider, compares.
// Depends on pwmtb_pkg, pwmtb_select, pwmtb_div, pwmtb_cmp.
//
//  channel   | handshake                    | beat
//  ----------+------------------------------+-------------------------------------------
//  request   | start high, busy low         | i_instance_req, i_frequency, i_duty_a/b
//  result    | o_valid strobe, one cycle    | o_target_instance .. o_status
//  registers | psel, penable, pwrite, pready| paddr, pwdata, prdata (min_frequency)
//
// A request is accepted every cycle; busy is always low.
// Each result passes two selection stages, eight divider stages (two quotient bits each)
// and three compare and output stages.
// Reset is synchronous, active low, and clears the valid bits and min_frequency.
// The receiver cannot stall, so nothing holds the pipeline.
module pwm_frequency_to_timebase import pwmtb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_instance_req,
    input  logic [31:0]        i_frequency,
    input  logic signed [15:0] i_duty_a,
    input  logic signed [15:0] i_duty_b,
    output logic               o_valid,
    output logic [1:0]         o_target_instance,
    output logic [2:0]         o_clock_div_index,
    output logic [2:0]         o_highspeed_div_index,
    output logic [15:0]        o_period,
    output logic [15:0]        o_compare_a,
    output logic [15:0]        o_compare_b,
    output logic [1:0]         o_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [31:0] r_min_freq;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign prdata = (paddr == ADDR_MIN_FREQ) ? r_min_freq : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_freq <= '0;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_MIN_FREQ) begin
            r_min_freq <= pwdata;
        end
    end

    logic           w_sel_v;
    logic [31:0]    w_sel_f;
    logic [C_W-1:0] w_sel_c;
    logic [2:0]     w_sel_ci, w_sel_hi;
    t_side          w_sel_sd;

    pwmtb_select u_select (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (start && !busy),
        .i_instance_req (i_instance_req),
        .i_frequency    (i_frequency),
        .i_duty_a       (i_duty_a),
        .i_duty_b       (i_duty_b),
        .i_min_freq     (r_min_freq),
        .o_valid        (w_sel_v),
        .o_freq         (w_sel_f),
        .o_dividend     (w_sel_c),
        .o_ci           (w_sel_ci),
        .o_hi           (w_sel_hi),
        .o_side         (w_sel_sd)
    );

    logic           w_div_v;
    logic [Q_W-1:0] w_div_q;
    logic [2:0]     w_div_ci, w_div_hi;
    t_side          w_div_sd;

    pwmtb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_sel_v),
        .i_freq     (w_sel_f),
        .i_dividend (w_sel_c),
        .i_ci       (w_sel_ci),
        .i_hi       (w_sel_hi),
        .i_side     (w_sel_sd),
        .o_valid    (w_div_v),
        .o_quot     (w_div_q),
        .o_ci       (w_div_ci),
        .o_hi       (w_div_hi),
        .o_side     (w_div_sd)
    );

    pwmtb_cmp u_cmp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (w_div_v),
        .i_period              (w_div_q),
        .i_ci                  (w_div_ci),
        .i_hi                  (w_div_hi),
        .i_side                (w_div_sd),
        .o_valid               (o_valid),
        .o_target_instance     (o_target_instance),
        .o_clock_div_index     (o_clock_div_index),
        .o_highspeed_div_index (o_highspeed_div_index),
        .o_period              (o_period),
        .o_compare_a           (o_compare_a),
        .o_compare_b           (o_compare_b),
        .o_status              (o_status)
    );

    a_slow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_TOO_SLOW |->
            o_period == 16'd0 && o_compare_a == 16'd0 && o_compare_b == 16'd0 &&
            o_clock_div_index == 3'd0 && o_highspeed_div_index == 3'd0)
        else $error("too-slow result carries programmed values");

    a_cmp_le_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_compare_a <= o_period && o_compare_b <= o_period)
        else $error("compare value above period");

    a_div_feeds_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_v |-> ##3 o_valid)
        else $error("divider beat lost before output");

endmodule

### tb/pwm_timebase_checker.sv
`timescale 1ns / 1ps
// Checker for the PWM time-base calculator: predicts each result from the request and
// the min_frequency register, then compares field by field. Depends on pwmtb_pkg.
module pwm_timebase_checker import pwmtb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         i_instance_req,
    input  logic [31:0]        i_frequency,
    input  logic signed [15:0] i_duty_a,
    input  logic signed [15:0] i_duty_b,
    input  logic               o_valid,
    input  logic [1:0]         o_target_instance,
    input  logic [2:0]         o_clock_div_index,
    input  logic [2:0]         o_highspeed_div_index,
    input  logic [15:0]        o_period,
    input  logic [15:0]        o_compare_a,
    input  logic [15:0]        o_compare_b,
    input  logic [1:0]         o_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct {
        logic [1:0]  inst;
        logic [2:0]  ci;
        logic [2:0]  hi;
        logic [15:0] period;
        logic [15:0] cmp_a;
        logic [15:0] cmp_b;
        t_status     status;
    } t_timebase;

    t_timebase   timebase_q[$];
    logic [31:0] min_freq;

    function automatic longint unsigned hs_mult(input int j);
        case (j)
            0: return 1;
            1: return 2;
            2: return 4;
            3: return 6;
            4: return 8;
            5: return 10;
            6: return 12;
            default: return 14;
        endcase
    endfunction

    function automatic logic [15:0] duty_compare(input longint unsigned per,
                                                 input logic signed [15:0] duty);
        longint unsigned d;
        if (duty < 0) d = 64'd0;
        else if (duty > FULL_DUTY) d = 64'(FULL_DUTY);
        else d = 64'(duty);
        return 16'((per * d) / FULL_DUTY);
    endfunction

    function automatic t_timebase compute_timebase(input logic [1:0] inst,
                                                   input logic [31:0] f,
                                                   input logic signed [15:0] da,
                                                   input logic signed [15:0] db);
        t_timebase r;
        longint unsigned best, p, per;
        logic bad;
        r.inst = inst;
        r.ci = 3'd7; r.hi = 3'd7; r.period = 16'd0; r.cmp_a = 16'd0; r.cmp_b = 16'd0;
        if (f == 0 || NS_SCALED > MAX_DIV * DIV_UNIT * f) begin
            r.ci = 3'd0; r.hi = 3'd0;
            r.status = ST_TOO_SLOW;
            return r;
        end
        bad = (f <= min_freq) || da < 0 || da > FULL_DUTY || db < 0 || db > FULL_DUTY;
        best = 1792;
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
                p = hs_mult(j) << i;
                if (p < best && p * DIV_UNIT * f > NS_SCALED) begin
                    best = p; r.ci = 3'(i); r.hi = 3'(j);
                end
            end
        end
        per = NS_SCALED / (longint'(f) * TICK_NS * best);
        if (per > 65535) per = 65535;
        r.period = 16'(per);
        r.cmp_a = duty_compare(per, da);
        r.cmp_b = duty_compare(per, db);
        r.status = bad ? ST_INVALID : ST_OK;
        return r;
    endfunction

    assign o_pending = timebase_q.size();

    always @(posedge i_clk) begin
        t_timebase e;
        if (!i_rst_n) begin
            min_freq <= '0;
            o_errors <= 0;
        end else begin
            // a request is predicted with the register value before any same-edge write
            if (o_valid) begin
                if (timebase_q.size() == 0) begin
                    $error("result with no request outstanding");
                    o_errors <= o_errors + 1;
                end else begin
                    e = timebase_q.pop_front();
                    if (o_target_instance !== e.inst || o_clock_div_index !== e.ci ||
                        o_highspeed_div_index !== e.hi || o_period !== e.period ||
                        o_compare_a !== e.cmp_a || o_compare_b !== e.cmp_b ||
                        o_status !== e.status) begin
                        o_errors <= o_errors + 1;
                        if (o_target_instance !== e.inst)
                            $error("target_instance exp %0d got %0d", e.inst, o_target_instance);
                        if (o_clock_div_index !== e.ci)
                            $error("clock_div_index exp %0d got %0d", e.ci, o_clock_div_index);
                        if (o_highspeed_div_index !== e.hi)
                            $error("highspeed_div_index exp %0d got %0d",
                                   e.hi, o_highspeed_div_index);
                        if (o_period !== e.period)
                            $error("period exp %0d got %0d", e.period, o_period);
                        if (o_compare_a !== e.cmp_a)
                            $error("compare_a exp %0d got %0d", e.cmp_a, o_compare_a);
                        if (o_compare_b !== e.cmp_b)
                            $error("compare_b exp %0d got %0d", e.cmp_b, o_compare_b);
                        if (o_status !== e.status)
                            $error("status exp %0d got %0d", e.status, o_status);
                    end
                end
            end
            if (start && !busy)
                timebase_q.push_back(compute_timebase(i_instance_req, i_frequency,
                                                      i_duty_a, i_duty_b));
            if (psel && penable && pwrite && pready && paddr == ADDR_MIN_FREQ)
                min_freq <= pwdata;
        end
    end

endmodule

### tb/pwm_frequency_to_timebase_tb.sv
`timescale 1ns / 1ps
// Testbench top for pwm_frequency_to_timebase: drives requests and register writes,
// gives the verdict. Depends on pwmtb_pkg, the block and pwm_timebase_checker.
module pwm_frequency_to_timebase_tb import pwmtb_pkg::*;;

    localparam int LATENCY   = 13;
    localparam int CYCLE_CAP = 200000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_instance_req = '0;
    logic [31:0]        i_frequency = '0;
    logic signed [15:0] i_duty_a = '0;
    logic signed [15:0] i_duty_b = '0;
    logic               o_valid;
    logic [1:0]         o_target_instance;
    logic [2:0]         o_clock_div_index;
    logic [2:0]         o_highspeed_div_index;
    logic [15:0]        o_period;
    logic [15:0]        o_compare_a;
    logic [15:0]        o_compare_b;
    logic [1:0]         o_status;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [1:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    int                 mismatches;
    int                 pending;
    int                 cycles = 0;
    logic               no_idle = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    pwm_frequency_to_timebase u_top (.*);

    pwm_timebase_checker u_chk (.*, .o_errors(mismatches), .o_pending(pending));

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_min_freq(input logic [31:0] v);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_MIN_FREQ; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // send one request beat, with a random gap before it unless idling is off
    task automatic send_request(input logic [1:0] inst, input logic [31:0] f,
                                input logic [15:0] da, input logic [15:0] db);
        while (!no_idle && $urandom_range(99) < 33) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_instance_req <= inst; i_frequency <= f; i_duty_a <= da; i_duty_b <= db;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic [15:0] pick_duty();
        case ($urandom_range(5))
            0: return 16'($urandom);
            1: return 16'($urandom_range(25600, 25601));
            2: return 16'hffff;
            default: return 16'($urandom_range(25600));
        endcase
    endfunction

    // mostly frequencies that reach the prescaler search, across its decades
    function automatic logic [31:0] pick_freq();
        case ($urandom_range(7))
            0: return $urandom;
            1: return $urandom_range(300);
            2: return $urandom_range(230, 215);
            default: return $urandom_range(32'd256 << $urandom_range(16), 219);
        endcase
    endfunction

    task automatic random_phase(input int n);
        for (int k = 0; k < n; k++)
            send_request(2'($urandom), pick_freq(), pick_duty(), pick_duty());
        start <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero and slow edge, search edges, top frequency, duty extremes
        no_idle = 1'b1;
        send_request(2'd0, 32'd0, 16'd0, 16'd0);
        send_request(2'd1, 32'(SLOW_MAX), 16'd100, 16'd100);
        send_request(2'd2, 32'(SLOW_MAX + 1), 16'd25600, 16'd0);
        send_request(2'd3, 32'd256, 16'h8000, 16'h7fff);
        send_request(2'd0, 32'hffffffff, 16'd12800, 16'd25601);
        send_request(2'd1, 32'd1, 16'hffff, 16'd1);
        send_request(2'd2, 32'd25600, 16'd25599, 16'd6400);
        send_request(2'd1, 32'd2560000, 16'd25600, 16'd25600);
        send_request(2'd0, 32'd390, 16'd1, 16'd12800);
        send_request(2'd3, 32'd1 << 20, 16'd0, 16'h7fff);
        start <= 1'b0;
        drain_results();

        write_min_freq(32'hffffffff);
        send_request(2'd0, 32'hffffffff, 16'd100, 16'd100);
        send_request(2'd1, 32'd25600, 16'd100, 16'd100);
        start <= 1'b0;
        drain_results();
        write_min_freq(32'd25600);
        send_request(2'd0, 32'd25600, 16'd100, 16'd100);
        send_request(2'd1, 32'd25601, 16'd100, 16'd100);
        start <= 1'b0;
        drain_results();

        // random phases under several thresholds; first one without idling
        random_phase(150);
        drain_results();
        no_idle = 1'b0;
        write_min_freq(32'd0);
        random_phase(250);
        drain_results();
        write_min_freq($urandom);
        random_phase(200);
        drain_results();
        write_min_freq($urandom_range(100000));
        random_phase(200);
        drain_results();

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
